@@ hw/rtl/vmt_pkg.sv @@
// Shared constants and types of the vertex matrix transform unit.
`timescale 1ns / 1ps
package vmt_pkg;

  localparam int CoordW   = 32;
  localparam int RegW     = 64;
  localparam int NumRegs  = 8;
  localparam int IdxW     = 4;
  localparam int ProdW    = 64;
  localparam int SumW     = 66;
  localparam int MagW     = 64;
  localparam int FracBits = 16;
  localparam int DivSteps = 32;
  localparam int NumCols  = 3;

  typedef enum logic [1:0] {
    REQ_AFFINE = 2'd0,
    REQ_PROJ   = 2'd1,
    REQ_LINEAR = 2'd2,
    REQ_SPARE  = 2'd3
  } req_type_t;

  localparam logic [CoordW-1:0] QMax = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] QMin = 32'h8000_0000;

  localparam logic [RegW-1:0] RegReset [NumRegs] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic [MagW-1:0]   rem;
    logic [15:0]       nlo;
    logic [DivSteps-1:0] quo;
    logic              ovf;
    logic              nneg;
    logic [CoordW-1:0] lin_out;
    logic              lin_clip;
  } col_t;

  typedef struct packed {
    logic              proj;
    logic              zw;
    logic [MagW-1:0]   dmag;
    logic              dneg;
    col_t [NumCols-1:0] col;
  } div_t;

endpackage

@@ hw/rtl/vmt_in_if.sv @@
// Input channel of the vertex matrix transform unit.
`timescale 1ns / 1ps
interface vmt_in_if
  import vmt_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic signed [CoordW-1:0] vec_x;
  logic signed [CoordW-1:0] vec_y;
  logic signed [CoordW-1:0] vec_z;
  modport source (output valid, req_type, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, req_type, vec_x, vec_y, vec_z, output ready);
endinterface

@@ hw/rtl/vmt_out_if.sv @@
// Output channel of the vertex matrix transform unit.
`timescale 1ns / 1ps
interface vmt_out_if
  import vmt_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] out_x;
  logic signed [CoordW-1:0] out_y;
  logic signed [CoordW-1:0] out_z;
  logic                     zero_w;
  logic                     clipped;
  modport source (output valid, out_x, out_y, out_z, zero_w, clipped, input ready);
  modport sink (input valid, out_x, out_y, out_z, zero_w, clipped, output ready);
endinterface

@@ hw/rtl/vertex_matrix_transform_unit.sv @@
// Top level: pipelined 4x4 homogeneous vertex transform with divide by w for projective requests.
//
//   channel  | direction | contents
//   in_ch    | sink      | req_type, vec_x, vec_y, vec_z
//   out_ch   | source    | out_x, out_y, out_z, zero_w, clipped
//   cfg      | write     | cfg_we, cfg_index, cfg_data (eight matrix registers)
//
// Every item passes these registered stages from acceptance to the output register: input,
// multiply, sum, magnitude, overflow check, 32 restoring divide steps, result.
// One item enters per cycle while no result waits at the output.
// The whole pipeline advances together and holds while a result waits.
// Reset clears the valid bits and loads the matrix registers from RegReset.
`timescale 1ns / 1ps
module vertex_matrix_transform_unit
  import vmt_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [IdxW-1:0] cfg_index,
  input  logic [RegW-1:0] cfg_data,
  vmt_in_if.sink          in_ch,
  vmt_out_if.source       out_ch
);

  localparam int NumStages = DivSteps + 6;

  logic [RegW-1:0] mreg [NumRegs];
  logic [NumStages:1] v;
  logic adv;

  logic [1:0]               s1_type;
  logic signed [CoordW-1:0] s1_vec [3];

  logic signed [ProdW-1:0] s2_prod [4][3];
  logic                    s2_proj;
  logic                    s2_trans;

  logic signed [SumW-1:0] s3_sum [4];
  logic                   s3_proj;

  div_t s4;
  div_t divs [DivSteps+1];
  div_t step_next [DivSteps+1];
  div_t s5_next;

  logic signed [CoordW-1:0] me [4][4];
  logic signed [SumW-1:0]   sum_next [4];
  div_t                     s4_next;

  logic [CoordW-1:0] res_next [NumCols];
  logic [NumCols-1:0] clip_next;

  assign adv = !v[NumStages] || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = v[NumStages];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) mreg[i] <= RegReset[i];
    end else if (cfg_we && cfg_index < IdxW'(NumRegs)) begin
      mreg[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NumStages-1:1], in_ch.valid};
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        me[r][c] = (c % 2 == 1) ? mreg[r*2 + c/2][63:32] : mreg[r*2 + c/2][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_type   <= in_ch.req_type;
      s1_vec[0] <= in_ch.vec_x;
      s1_vec[1] <= in_ch.vec_y;
      s1_vec[2] <= in_ch.vec_z;
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) s2_prod[c][r] <= s1_vec[r] * me[r][c];
      end
      s2_proj  <= (s1_type == REQ_PROJ);
      s2_trans <= (s1_type == REQ_PROJ) || (s1_type == REQ_AFFINE);
      for (int c = 0; c < 4; c++) s3_sum[c] <= sum_next[c];
      s3_proj <= s2_proj;
      s4 <= s4_next;
      divs[0] <= s5_next;
      for (int j = 1; j <= DivSteps; j++) divs[j] <= step_next[j];
      out_ch.out_x   <= res_next[0];
      out_ch.out_y   <= res_next[1];
      out_ch.out_z   <= res_next[2];
      out_ch.zero_w  <= divs[DivSteps].proj && divs[DivSteps].zw;
      out_ch.clipped <= |clip_next;
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum_next[c] = SumW'(s2_prod[c][0]) + SumW'(s2_prod[c][1]) + SumW'(s2_prod[c][2]);
      if (s2_trans) sum_next[c] = sum_next[c] + SumW'(signed'({me[3][c], 16'h0000}));
    end
  end

  always_comb begin
    logic signed [SumW-1:0] neg_sum;
    logic [49:0] sh;
    s4_next = '0;
    s4_next.proj = s3_proj;
    s4_next.zw   = (s3_sum[3] == '0);
    neg_sum      = -s3_sum[3];
    s4_next.dneg = s3_sum[3][SumW-1];
    s4_next.dmag = s3_sum[3][SumW-1] ? neg_sum[MagW-1:0] : s3_sum[3][MagW-1:0];
    for (int c = 0; c < NumCols; c++) begin
      neg_sum = -s3_sum[c];
      s4_next.col[c].nneg = s3_sum[c][SumW-1];
      s4_next.col[c].rem  = s3_sum[c][SumW-1] ? neg_sum[MagW-1:0] : s3_sum[c][MagW-1:0];
      sh = s3_sum[c][SumW-1:16];
      if (sh[49:31] != '0 && sh[49:31] != '1) begin
        s4_next.col[c].lin_out  = sh[49] ? QMin : QMax;
        s4_next.col[c].lin_clip = 1'b1;
      end else begin
        s4_next.col[c].lin_out  = sh[31:0];
        s4_next.col[c].lin_clip = 1'b0;
      end
    end
  end

  always_comb begin
    s5_next = s4;
    for (int c = 0; c < NumCols; c++) begin
      s5_next.col[c].ovf = {16'h0000, s4.col[c].rem[MagW-1:FracBits]} >= s4.dmag;
      s5_next.col[c].nlo = s4.col[c].rem[15:0];
      s5_next.col[c].rem = MagW'(s4.col[c].rem[MagW-1:FracBits]);
      s5_next.col[c].quo = '0;
    end
  end

  always_comb begin
    logic [MagW:0] t;
    logic ge;
    step_next[0] = divs[0];
    for (int j = 1; j <= DivSteps; j++) begin
      step_next[j] = divs[j-1];
      for (int c = 0; c < NumCols; c++) begin
        t  = {divs[j-1].col[c].rem, divs[j-1].col[c].nlo[15]};
        ge = t >= {1'b0, divs[j-1].dmag};
        step_next[j].col[c].rem = ge ? MagW'(t - {1'b0, divs[j-1].dmag}) : t[MagW-1:0];
        step_next[j].col[c].nlo = {divs[j-1].col[c].nlo[14:0], 1'b0};
        step_next[j].col[c].quo = {divs[j-1].col[c].quo[DivSteps-2:0], ge};
      end
    end
  end

  always_comb begin
    div_t f;
    logic [CoordW-1:0] mag;
    logic neg;
    f = divs[DivSteps];
    for (int c = 0; c < NumCols; c++) begin
      mag = f.col[c].quo;
      neg = f.col[c].nneg ^ f.dneg;
      if (!f.proj) begin
        res_next[c]  = f.col[c].lin_out;
        clip_next[c] = f.col[c].lin_clip;
      end else if (f.zw) begin
        res_next[c]  = f.col[c].nneg ? QMin : QMax;
        clip_next[c] = 1'b1;
      end else if (f.col[c].ovf) begin
        res_next[c]  = neg ? QMin : QMax;
        clip_next[c] = 1'b1;
      end else if (neg) begin
        clip_next[c] = mag[31] && (|mag[30:0]);
        res_next[c]  = clip_next[c] ? QMin : -mag;
      end else begin
        clip_next[c] = mag[31];
        res_next[c]  = mag[31] ? QMax : mag;
      end
    end
  end

endmodule
